// ===== hdl/ccw_pkg.sv =====
// ccw_pkg: shared constants, codes and types of the coin change unit
// used by ccw_table and coin_change_ways_and_min_coins_unit; no dependencies
package ccw_pkg;

  // defaults for the top level parameters
  localparam int MAX_COINS_DEF  = 16;
  localparam int MAX_AMOUNT_DEF = 1023;
  localparam int WAYS_WIDTH_DEF = 32;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int COIN_W     = 10;
  localparam int AMOUNT_W   = 10;
  localparam int OUT_WAYS_W = 32;
  localparam int MIN_OUT_W  = 10;
  localparam int STATUS_W   = 2;

  // fewest-coins entry: a count below 1024 plus an infinity marker
  localparam int MIN_W = 11;
  localparam logic [MIN_W-1:0] MIN_INF = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SOLVE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_COINS    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CFETCH,
    S_CWAIT,
    S_SWEEP,
    S_FINAL,
    S_FINWAIT,
    S_DONE
  } state_t;

  // commands from the sequencer to the table
  typedef struct packed {
    logic init_wr;     // write the starting value at addr_a
    logic init_first;  // starting value of amount zero
    logic issue;       // read entries at addr_a and addr_b
    logic upd;         // the read pair feeds an update of addr_a
  } tbl_cmd_t;

  typedef struct packed {
    logic upd_busy;    // an update write is in its second stage
  } tbl_sts_t;

endpackage

// ===== hdl/coin_change_ways_and_min_coins_unit.sv =====
// coin_change_ways_and_min_coins_unit: top level, operation sequencer,
// coin list memory and result register; uses ccw_pkg and ccw_table
//
// Usage: load denominations with append transfers (a zero coin, or an append
// with MAX_COINS coins already held, is dropped), drop the list with a clear,
// and send a solve with the target amount. Clear and append give no result.
// A solve gives exactly one result: the number of unordered combinations
// (saturating at 2^WAYS_WIDTH-1 with a sticky flag), the fewest coins and a
// status (ok, unreachable, no coins loaded). A solve with an empty list or an
// amount above MAX_AMOUNT answers without a sweep. Otherwise the solve walks
// one table memory (two read ports, one write port, registered reads): it
// seeds the entries 0..amount, then for each loaded coin c not above the
// amount fetches the coin and does read-modify-write on entries c..amount,
// one entry per cycle (a coin above the amount is fetched and skipped), then
// reads the answer and loads the output register. The read/write port of
// the table sets this pace; an update that reads the entry written on the
// same edge takes the value from a forwarding register. While a solve runs
// the input is stalled; once the result sits in the output register new
// clear, append and solve transfers are taken, and a solve finished while
// the previous result has not been transferred yet holds the input stalled
// until it leaves. The tables need no clearing after reset.
module coin_change_ways_and_min_coins_unit #(
  parameter int MAX_COINS  = ccw_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = ccw_pkg::MAX_AMOUNT_DEF,
  parameter int WAYS_WIDTH = ccw_pkg::WAYS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ccw_pkg::OP_W-1:0]        in_operation,
  input  logic [ccw_pkg::COIN_W-1:0]      in_coin_value,
  input  logic [ccw_pkg::AMOUNT_W-1:0]    in_amount,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ccw_pkg::OUT_WAYS_W-1:0]  out_ways_count,
  output logic                            out_ways_saturated,
  output logic [ccw_pkg::MIN_OUT_W-1:0]   out_min_coins,
  output logic [ccw_pkg::STATUS_W-1:0]    out_status
);

  localparam int AW     = ccw_pkg::AMOUNT_W;
  localparam int CW     = ccw_pkg::COIN_W;
  localparam int AMT_W  = $clog2(MAX_AMOUNT + 1);
  localparam int CCNT_W = $clog2(MAX_COINS + 1);
  localparam int CIDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam logic [CCNT_W-1:0] CCNT_ONE = CCNT_W'(1);
  localparam logic [CCNT_W-1:0] CCNT_MAX = CCNT_W'(MAX_COINS);
  localparam logic [AW-1:0]     AMT_ONE  = AW'(1);

  ccw_pkg::state_t state_r, state_nxt;

  // coin list
  logic [CW-1:0]     coin_mem [MAX_COINS];
  logic [CW-1:0]     coin_q_r;
  logic              coin_wr, coin_rd;
  logic [CCNT_W-1:0] coin_cnt_r, coin_cnt_nxt;

  // sweep counters
  logic [AW-1:0]     amt_r, amt_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [CCNT_W-1:0] k_r, k_nxt;
  logic [AW-1:0]     j_back;
  logic              in_xfer, out_free, last_coin, solve_short;

  // table port
  ccw_pkg::tbl_cmd_t          tbl_cmd;
  ccw_pkg::tbl_sts_t          tbl_sts;
  logic [AMT_W-1:0]           tbl_addr_a, tbl_addr_b;
  logic [WAYS_WIDTH-1:0]      tbl_ways;
  logic                       tbl_flag;
  logic [ccw_pkg::MIN_W-1:0]  tbl_min;

  // pending result and output register
  logic [ccw_pkg::OUT_WAYS_W-1:0] res_ways_r, res_ways_nxt;
  logic                           res_sat_r, res_sat_nxt;
  logic [ccw_pkg::MIN_OUT_W-1:0]  res_min_r, res_min_nxt;
  logic [ccw_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ccw_pkg::OUT_WAYS_W-1:0] out_ways_r, out_ways_nxt;
  logic                           out_sat_r, out_sat_nxt;
  logic [ccw_pkg::MIN_OUT_W-1:0]  out_min_r, out_min_nxt;
  logic [ccw_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;

  assign in_xfer   = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign last_coin = ((k_r + CCNT_ONE) == coin_cnt_r);
  assign j_back    = j_r - coin_q_r;
  // empty list or amount beyond the table: answered without a sweep
  assign solve_short = (coin_cnt_r == '0) || (32'(in_amount) > 32'(MAX_AMOUNT));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccw_pkg::S_IDLE: begin
        if (in_xfer && (in_operation == ccw_pkg::OP_SOLVE)) begin
          state_nxt = solve_short ? ccw_pkg::S_DONE : ccw_pkg::S_INIT;
        end
      end
      ccw_pkg::S_INIT: begin
        if (j_r == amt_r) begin
          state_nxt = ccw_pkg::S_CFETCH;
        end
      end
      ccw_pkg::S_CFETCH: begin
        state_nxt = ccw_pkg::S_CWAIT;
      end
      ccw_pkg::S_CWAIT: begin
        if (coin_q_r <= amt_r) begin
          state_nxt = ccw_pkg::S_SWEEP;
        end else if (last_coin) begin
          state_nxt = ccw_pkg::S_FINAL;
        end else begin
          state_nxt = ccw_pkg::S_CFETCH;
        end
      end
      ccw_pkg::S_SWEEP: begin
        if (j_r == amt_r) begin
          state_nxt = last_coin ? ccw_pkg::S_FINAL : ccw_pkg::S_CFETCH;
        end
      end
      ccw_pkg::S_FINAL: begin
        state_nxt = ccw_pkg::S_FINWAIT;
      end
      ccw_pkg::S_FINWAIT: begin
        state_nxt = ccw_pkg::S_DONE;
      end
      ccw_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ccw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ccw_pkg::S_IDLE;
      end
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    coin_wr    = 1'b0;
    coin_rd    = 1'b0;
    tbl_cmd    = '0;
    tbl_addr_a = AMT_W'(j_r);
    tbl_addr_b = AMT_W'(j_back);
    case (state_r)
      ccw_pkg::S_IDLE: begin
        // input is never stalled here, so valid alone marks a transfer
        in_stall = 1'b0;
        coin_wr  = in_valid && (in_operation == ccw_pkg::OP_APPEND) &&
                   (in_coin_value != '0) && (coin_cnt_r < CCNT_MAX);
      end
      ccw_pkg::S_INIT: begin
        tbl_cmd.init_wr    = 1'b1;
        tbl_cmd.init_first = (j_r == '0);
      end
      ccw_pkg::S_CFETCH: begin
        coin_rd = 1'b1;
      end
      ccw_pkg::S_SWEEP: begin
        tbl_cmd.issue = 1'b1;
        tbl_cmd.upd   = 1'b1;
      end
      ccw_pkg::S_FINAL: begin
        // answer read; may need the last update through forwarding
        tbl_cmd.issue = 1'b1;
        tbl_addr_a    = AMT_W'(amt_r);
        tbl_addr_b    = AMT_W'(amt_r);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    coin_cnt_nxt   = coin_cnt_r;
    amt_nxt        = amt_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    res_ways_nxt   = res_ways_r;
    res_sat_nxt    = res_sat_r;
    res_min_nxt    = res_min_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_ways_nxt   = out_ways_r;
    out_sat_nxt    = out_sat_r;
    out_min_nxt    = out_min_r;
    out_status_nxt = out_status_r;
    case (state_r)
      ccw_pkg::S_IDLE: begin
        if (in_xfer && (in_operation == ccw_pkg::OP_CLEAR)) begin
          coin_cnt_nxt = '0;
        end
        if (coin_wr) begin
          coin_cnt_nxt = coin_cnt_r + CCNT_ONE;
        end
        if (in_xfer && (in_operation == ccw_pkg::OP_SOLVE)) begin
          amt_nxt      = in_amount;
          j_nxt        = '0;
          k_nxt        = '0;
          res_ways_nxt = '0;
          res_sat_nxt  = 1'b0;
          res_min_nxt  = '0;
          res_status_nxt = (coin_cnt_r == '0) ? ccw_pkg::ST_NO_COINS
                                              : ccw_pkg::ST_UNREACHABLE;
        end
      end
      ccw_pkg::S_INIT: begin
        if (j_r != amt_r) begin
          j_nxt = j_r + AMT_ONE;
        end
      end
      ccw_pkg::S_CWAIT: begin
        if (coin_q_r <= amt_r) begin
          j_nxt = coin_q_r;
        end else begin
          k_nxt = k_r + CCNT_ONE;
        end
      end
      ccw_pkg::S_SWEEP: begin
        if (j_r == amt_r) begin
          k_nxt = k_r + CCNT_ONE;
        end else begin
          j_nxt = j_r + AMT_ONE;
        end
      end
      ccw_pkg::S_FINWAIT: begin
        if (tbl_min == ccw_pkg::MIN_INF) begin
          res_ways_nxt   = '0;
          res_sat_nxt    = 1'b0;
          res_min_nxt    = '0;
          res_status_nxt = ccw_pkg::ST_UNREACHABLE;
        end else begin
          res_ways_nxt   = ccw_pkg::OUT_WAYS_W'(tbl_ways);
          res_sat_nxt    = tbl_flag;
          res_min_nxt    = ccw_pkg::MIN_OUT_W'(tbl_min);
          res_status_nxt = ccw_pkg::ST_OK;
        end
      end
      ccw_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_ways_nxt   = res_ways_r;
          out_sat_nxt    = res_sat_r;
          out_min_nxt    = res_min_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
        j_nxt = j_r;
      end
    endcase
  end

  // coin list memory
  always_ff @(posedge clk) begin
    if (coin_wr) begin
      coin_mem[coin_cnt_r[CIDX_W-1:0]] <= in_coin_value;
    end
    if (coin_rd) begin
      coin_q_r <= coin_mem[k_r[CIDX_W-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccw_pkg::S_IDLE;
      coin_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coin_cnt_r  <= coin_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    amt_r        <= amt_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    res_ways_r   <= res_ways_nxt;
    res_sat_r    <= res_sat_nxt;
    res_min_r    <= res_min_nxt;
    res_status_r <= res_status_nxt;
    out_ways_r   <= out_ways_nxt;
    out_sat_r    <= out_sat_nxt;
    out_min_r    <= out_min_nxt;
    out_status_r <= out_status_nxt;
  end

  ccw_table #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .WAYS_WIDTH (WAYS_WIDTH),
    .AMT_W      (AMT_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tbl_cmd),
    .addr_a  (tbl_addr_a),
    .addr_b  (tbl_addr_b),
    .rd_ways (tbl_ways),
    .rd_flag (tbl_flag),
    .rd_min  (tbl_min),
    .sts     (tbl_sts)
  );

  assign out_valid          = out_valid_r;
  assign out_ways_count     = out_ways_r;
  assign out_ways_saturated = out_sat_r;
  assign out_min_coins      = out_min_r;
  assign out_status         = out_status_r;

  // coin count never passes the list capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    coin_cnt_r <= CCNT_MAX)
    else $error("coin count above capacity");

  // sweep index stays between the coin value and the target
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccw_pkg::S_SWEEP) |-> ((j_r >= coin_q_r) && (j_r <= amt_r)))
    else $error("sweep index out of range");

  // seeding never meets an update still in flight
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(tbl_cmd.init_wr && tbl_sts.upd_busy))
    else $error("seed write collides with update write");

  // a non-ok result carries zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ccw_pkg::ST_OK)) |->
      ((out_ways_r == '0) && !out_sat_r && (out_min_r == '0)))
    else $error("non-ok result with nonzero fields");

  // leaving the result state always leaves a result in the output register
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ($past(state_r) == ccw_pkg::S_DONE) &&
     (state_r == ccw_pkg::S_IDLE)) |-> out_valid_r)
    else $error("result lost on leaving done state");

endmodule

// ===== hdl/ccw_table.sv =====
// ccw_table: ways / fewest-coins table in one memory with two read ports
// and the saturating update stage with write forwarding; uses ccw_pkg
module ccw_table #(
  parameter int MAX_AMOUNT = ccw_pkg::MAX_AMOUNT_DEF,
  parameter int WAYS_WIDTH = ccw_pkg::WAYS_WIDTH_DEF,
  parameter int AMT_W      = $clog2(MAX_AMOUNT + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ccw_pkg::tbl_cmd_t        cmd,
  input  logic [AMT_W-1:0]         addr_a,
  input  logic [AMT_W-1:0]         addr_b,
  output logic [WAYS_WIDTH-1:0]    rd_ways,
  output logic                     rd_flag,
  output logic [ccw_pkg::MIN_W-1:0] rd_min,
  output ccw_pkg::tbl_sts_t        sts
);

  localparam int MW    = ccw_pkg::MIN_W;
  localparam int ENT_W = 1 + WAYS_WIDTH + MW;
  localparam int DEPTH = MAX_AMOUNT + 1;
  localparam logic [WAYS_WIDTH-1:0] WAYS_TOP = '1;
  localparam logic [WAYS_WIDTH-1:0] WAYS_ONE = WAYS_WIDTH'(1);
  localparam logic [MW-1:0]         MIN_ONE  = MW'(1);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] q_a_r, q_b_r;

  logic             s2_vld_r, s2_vld_nxt;
  logic [AMT_W-1:0] s2_addr_r, s2_addr_nxt;
  logic             fwd_a_r, fwd_a_nxt;
  logic             fwd_b_r, fwd_b_nxt;
  logic [ENT_W-1:0] fwd_data_r, fwd_data_nxt;

  logic [ENT_W-1:0]      a_ent, b_ent, init_ent, upd_ent, wd;
  logic [WAYS_WIDTH-1:0] a_ways, b_ways, new_ways;
  logic                  a_flag, b_flag, new_flag;
  logic [MW-1:0]         a_min, b_min, b_min1, new_min;
  logic [WAYS_WIDTH:0]   sum;
  logic                  we;
  logic [AMT_W-1:0]      wa;

  // read data, replaced by the write that landed on the same edge
  assign a_ent = fwd_a_r ? fwd_data_r : q_a_r;
  assign b_ent = fwd_b_r ? fwd_data_r : q_b_r;

  assign a_min  = a_ent[MW-1:0];
  assign a_ways = a_ent[MW +: WAYS_WIDTH];
  assign a_flag = a_ent[ENT_W-1];
  assign b_min  = b_ent[MW-1:0];
  assign b_ways = b_ent[MW +: WAYS_WIDTH];
  assign b_flag = b_ent[ENT_W-1];

  // saturating way count, sticky flag and fewest-coins minimum
  always_comb begin
    sum      = {1'b0, a_ways} + {1'b0, b_ways};
    new_ways = sum[WAYS_WIDTH] ? WAYS_TOP : sum[WAYS_WIDTH-1:0];
    new_flag = a_flag | b_flag | sum[WAYS_WIDTH] | (sum[WAYS_WIDTH-1:0] == WAYS_TOP);
    b_min1   = b_min + MIN_ONE;
    if ((b_min != ccw_pkg::MIN_INF) && (b_min1 < a_min)) begin
      new_min = b_min1;
    end else begin
      new_min = a_min;
    end
  end

  assign upd_ent  = {new_flag, new_ways, new_min};
  assign init_ent = cmd.init_first ? {1'b0, WAYS_ONE, {MW{1'b0}}}
                                   : {1'b0, {WAYS_WIDTH{1'b0}}, ccw_pkg::MIN_INF};

  assign we = cmd.init_wr | s2_vld_r;
  assign wa = cmd.init_wr ? addr_a : s2_addr_r;
  assign wd = cmd.init_wr ? init_ent : upd_ent;

  always_comb begin
    s2_vld_nxt   = cmd.issue & cmd.upd;
    s2_addr_nxt  = addr_a;
    fwd_a_nxt    = cmd.issue & we & (addr_a == wa);
    fwd_b_nxt    = cmd.issue & we & (addr_b == wa);
    fwd_data_nxt = wd;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.issue) begin
      q_a_r <= mem[addr_a];
      q_b_r <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      fwd_a_r  <= 1'b0;
      fwd_b_r  <= 1'b0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
      fwd_a_r  <= fwd_a_nxt;
      fwd_b_r  <= fwd_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r  <= s2_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  assign rd_ways      = a_ways;
  assign rd_flag      = a_flag;
  assign rd_min       = a_min;
  assign sts.upd_busy = s2_vld_r;

endmodule
